/* rtl/core/ssrm_pkg.sv */
// Shared types and constants of the stereo soft ring modulator.
package ssrm_pkg;

  // Default widths handed to the top level
  localparam int unsigned SAMPLE_WIDTH_DEF = 24;
  localparam int unsigned PHASE_WIDTH_DEF  = 32;

  // Depth of the queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  // Register indexes of the configuration port
  localparam logic [1:0] CFG_LEFT_STEP  = 2'd0;
  localparam logic [1:0] CFG_RIGHT_STEP = 2'd1;
  localparam logic [1:0] CFG_SOAR_LEVEL = 2'd2;
  localparam logic [1:0] CFG_WET_LEVEL  = 2'd3;

  // Full wet share, Q1.16
  localparam logic [16:0] WET_FULL = 17'h1_0000;

  // Quarter-wave sine polynomial, Q1.30
  localparam logic [30:0] ONE30 = 31'h4000_0000;
  localparam logic [30:0] C1    = 31'd1686629713;
  localparam logic [30:0] C3    = 31'd693598668;
  localparam logic [30:0] C5    = 31'd85569306;
  localparam logic [30:0] C7    = 31'd5026995;

  // Last step of the polynomial sequence
  localparam logic [2:0] POLY_LAST = 3'd4;

  // Per-channel sequencer states
  typedef enum logic [3:0] {
    LANE_IDLE,
    LANE_POLY,
    LANE_PREP,
    LANE_PROD,
    LANE_ROOT,
    LANE_TRIM,
    LANE_SCALE,
    LANE_SUM,
    LANE_DONE
  } lane_state_e;

  // Lane status seen by the top level
  typedef struct packed {
    logic idle;
    logic done;
  } lane_status_t;

endpackage

/* rtl/core/ssrm_fifo.sv */
// Short register queue between the front and the back.
module ssrm_fifo #(
  parameter int unsigned WIDTH = 112,
  parameter int unsigned DEPTH = ssrm_pkg::QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             full_o,
  output logic             empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign empty_o = (count_q == '0);
  assign data_o  = mem_q[rd_ptr_q];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) full_o |-> !push_i || pop_i)
    else $error("queue written while full");
  assert property (@(posedge clk_i) disable iff (!rst_ni) empty_o |-> !pop_i)
    else $error("queue read while empty");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (push_i && !pop_i) |=> !empty_o)
    else $error("queue empty after write");

endmodule

/* rtl/core/ssrm_front.sv */
// Front end: accepts sample pairs and advances both phase accumulators.
module ssrm_front #(
  parameter int unsigned SAMPLE_WIDTH = ssrm_pkg::SAMPLE_WIDTH_DEF,
  parameter int unsigned PHASE_WIDTH  = ssrm_pkg::PHASE_WIDTH_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [SAMPLE_WIDTH-1:0]     left_sample_i,
  input  logic [SAMPLE_WIDTH-1:0]     right_sample_i,
  input  logic [31:0]                 left_step_i,
  input  logic [31:0]                 right_step_i,
  input  logic                        full_i,
  output logic                        push_o,
  output logic [2*SAMPLE_WIDTH+63:0]  data_o
);

  localparam int unsigned PW = PHASE_WIDTH;

  logic [PW-1:0] left_phase_q, left_phase_d;
  logic [PW-1:0] right_phase_q, right_phase_d;
  logic [31:0]   left_tap, right_tap;

  assign in_stall_o = full_i;
  assign push_o     = in_valid_i && !full_i;

  // Phase advance, modulo the accumulator width
  assign left_phase_d  = left_phase_q + PW'(left_step_i);
  assign right_phase_d = right_phase_q + PW'(right_step_i);

  // Top 32 bits of the new phase, zero-padded when narrower, form the turn fraction
  if (PW >= 32) begin : g_tap_wide
    assign left_tap  = left_phase_d[PW-1 -: 32];
    assign right_tap = right_phase_d[PW-1 -: 32];
  end else begin : g_tap_narrow
    assign left_tap  = {left_phase_d, {(32 - PW){1'b0}}};
    assign right_tap = {right_phase_d, {(32 - PW){1'b0}}};
  end

  assign data_o = {left_sample_i, right_sample_i, left_tap, right_tap};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_phase_q  <= '0;
      right_phase_q <= '0;
    end else if (push_o) begin
      left_phase_q  <= left_phase_d;
      right_phase_q <= right_phase_d;
    end
  end

endmodule

/* rtl/core/ssrm_lane.sv */
// One channel of the back end: sine, soft ring product, square root and mix.
module ssrm_lane #(
  parameter int unsigned SAMPLE_WIDTH = ssrm_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [SAMPLE_WIDTH-1:0]    sample_i,
  input  logic [31:0]                phase_i,
  input  logic [SAMPLE_WIDTH:0]      soar_s_i,
  input  logic [SAMPLE_WIDTH:0]      soar_k_i,
  input  logic [16:0]                wet_i,
  input  logic [16:0]                dry_i,
  input  logic                       take_i,
  output ssrm_pkg::lane_status_t     status_o,
  output logic [SAMPLE_WIDTH-1:0]    result_o
);

  localparam int unsigned SW    = SAMPLE_WIDTH;
  localparam int unsigned F     = SW - 1;
  localparam int unsigned MAG_W = SW + 1;
  localparam int unsigned MUL_W = (MAG_W > 31) ? MAG_W : 31;
  localparam int unsigned RAD_W = 2 * MAG_W;
  localparam int unsigned CNT_W = $clog2(MAG_W);
  localparam int unsigned PRD_W = MAG_W + 19;
  localparam int unsigned SUM_W = PRD_W + 1;
  localparam int unsigned SH_W  = SUM_W - 16;
  localparam int unsigned SINE_DOWN = (F <= 30) ? (30 - F) : 0;
  localparam int unsigned SINE_UP   = (F <= 30) ? 0 : (F - 30);
  localparam logic signed [SH_W-1:0] SAT_HI = SH_W'((64'd1 << F) - 64'd1);
  localparam logic signed [SH_W-1:0] SAT_LO = ~SAT_HI;

  ssrm_pkg::lane_state_e state_q, state_d;

  logic [2:0]               step_q;
  logic [CNT_W-1:0]         cnt_q;
  logic signed [SW-1:0]     x_q;
  logic                     neg_q;
  logic [30:0]              t_q, t2_q, s_q;
  logic [MAG_W-1:0]         b_q, inner_q, outer_q;
  logic [RAD_W-1:0]         rad_q;
  logic [MAG_W-1:0]         rem_q, root_q;
  logic                     zero_q, same_q;
  logic signed [MAG_W:0]    mod_q;
  logic signed [PRD_W-1:0]  wp_q, dp_q;
  logic [SW-1:0]            res_q;

  logic [MUL_W-1:0]         mul_a, mul_b;
  logic [2*MUL_W-1:0]       prod;
  logic [30:0]              prod_hi;
  logic [63:0]              y_ext, b_ext;
  logic signed [MAG_W-1:0]  x_ext;
  logic [MAG_W-1:0]         a_mag, ak, bk;
  logic [MAG_W+1:0]         rem_sh, trial;
  logic [MAG_W-1:0]         diff;
  logic signed [SUM_W-1:0]  sum;
  logic signed [SH_W-1:0]   sh;

  assign status_o.idle = (state_q == ssrm_pkg::LANE_IDLE);
  assign status_o.done = (state_q == ssrm_pkg::LANE_DONE);
  assign result_o      = res_q;

  // Shared multiplier operand selection
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ssrm_pkg::LANE_POLY: begin
        case (step_q)
          3'd0: begin
            mul_a = MUL_W'(t_q);
            mul_b = MUL_W'(t_q);
          end
          3'd1: begin
            mul_a = MUL_W'(ssrm_pkg::C7);
            mul_b = MUL_W'(t2_q);
          end
          3'd2, 3'd3: begin
            mul_a = MUL_W'(s_q);
            mul_b = MUL_W'(t2_q);
          end
          default: begin
            mul_a = MUL_W'(s_q);
            mul_b = MUL_W'(t_q);
          end
        endcase
      end
      ssrm_pkg::LANE_PROD: begin
        mul_a = MUL_W'(inner_q);
        mul_b = MUL_W'(outer_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod    = mul_a * mul_b;
  assign prod_hi = prod[30 +: 31];

  // Sine magnitude moved to the sample scale
  assign y_ext = 64'(prod_hi);
  assign b_ext = (y_ext >> SINE_DOWN) << SINE_UP;

  // Operand ordering of the soft ring product
  assign x_ext = MAG_W'(x_q);
  assign a_mag = x_q[SW-1] ? MAG_W'(-x_ext) : MAG_W'(x_ext);
  assign ak    = a_mag + soar_k_i;
  assign bk    = b_q + soar_k_i;

  // One root bit per cycle
  assign rem_sh = {rem_q, rad_q[RAD_W-1 -: 2]};
  assign trial  = {root_q, 2'b01};

  assign diff = (root_q > soar_s_i) ? root_q - soar_s_i : '0;

  // Mix sum, floor shift and saturation
  assign sum = SUM_W'(wp_q) + SUM_W'(dp_q);
  assign sh  = sum[SUM_W-1:16];

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ssrm_pkg::LANE_IDLE:  if (start_i) state_d = ssrm_pkg::LANE_POLY;
      ssrm_pkg::LANE_POLY:  if (step_q == ssrm_pkg::POLY_LAST) state_d = ssrm_pkg::LANE_PREP;
      ssrm_pkg::LANE_PREP:  state_d = ssrm_pkg::LANE_PROD;
      ssrm_pkg::LANE_PROD:  state_d = ssrm_pkg::LANE_ROOT;
      ssrm_pkg::LANE_ROOT:  if (cnt_q == CNT_W'(MAG_W - 1)) state_d = ssrm_pkg::LANE_TRIM;
      ssrm_pkg::LANE_TRIM:  state_d = ssrm_pkg::LANE_SCALE;
      ssrm_pkg::LANE_SCALE: state_d = ssrm_pkg::LANE_SUM;
      ssrm_pkg::LANE_SUM:   state_d = ssrm_pkg::LANE_DONE;
      ssrm_pkg::LANE_DONE:  if (take_i) state_d = ssrm_pkg::LANE_IDLE;
      default:              state_d = ssrm_pkg::LANE_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ssrm_pkg::LANE_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Step and bit counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
      cnt_q  <= '0;
    end else begin
      case (state_q)
        ssrm_pkg::LANE_IDLE: step_q <= '0;
        ssrm_pkg::LANE_POLY: step_q <= step_q + 3'd1;
        ssrm_pkg::LANE_PROD: cnt_q  <= '0;
        ssrm_pkg::LANE_ROOT: cnt_q  <= cnt_q + 1'b1;
        default: ;
      endcase
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      ssrm_pkg::LANE_IDLE: begin
        if (start_i) begin
          x_q   <= sample_i;
          neg_q <= phase_i[31];
          t_q   <= phase_i[30] ? ssrm_pkg::ONE30 - {1'b0, phase_i[29:0]}
                               : {1'b0, phase_i[29:0]};
        end
      end
      ssrm_pkg::LANE_POLY: begin
        case (step_q)
          3'd0:    t2_q <= prod_hi;
          3'd1:    s_q  <= ssrm_pkg::C5 - prod_hi;
          3'd2:    s_q  <= ssrm_pkg::C3 - prod_hi;
          3'd3:    s_q  <= ssrm_pkg::C1 - prod_hi;
          default: b_q  <= b_ext[MAG_W-1:0];
        endcase
      end
      ssrm_pkg::LANE_PREP: begin
        zero_q <= (x_q == '0) || (b_q == '0);
        same_q <= (x_q[SW-1] == neg_q);
        if (a_mag < bk) begin
          inner_q <= b_q;
          outer_q <= ak;
        end else begin
          inner_q <= a_mag;
          outer_q <= bk;
        end
      end
      ssrm_pkg::LANE_PROD: begin
        rad_q  <= prod[RAD_W-1:0];
        rem_q  <= '0;
        root_q <= '0;
      end
      ssrm_pkg::LANE_ROOT: begin
        rad_q <= rad_q << 2;
        if (rem_sh >= trial) begin
          rem_q  <= MAG_W'(rem_sh - trial);
          root_q <= {root_q[MAG_W-2:0], 1'b1};
        end else begin
          rem_q  <= MAG_W'(rem_sh);
          root_q <= {root_q[MAG_W-2:0], 1'b0};
        end
      end
      ssrm_pkg::LANE_TRIM: begin
        if (zero_q) begin
          mod_q <= '0;
        end else if (same_q) begin
          mod_q <= $signed({1'b0, diff});
        end else begin
          mod_q <= -$signed({1'b0, diff});
        end
      end
      ssrm_pkg::LANE_SCALE: begin
        wp_q <= PRD_W'($signed({1'b0, wet_i})) * PRD_W'(mod_q);
        dp_q <= PRD_W'($signed({1'b0, dry_i})) * PRD_W'(x_q);
      end
      ssrm_pkg::LANE_SUM: begin
        if (sh > SAT_HI) begin
          res_q <= SW'(SAT_HI);
        end else if (sh < SAT_LO) begin
          res_q <= SW'(SAT_LO);
        end else begin
          res_q <= sh[SW-1:0];
        end
      end
      default: ;
    endcase
  end

endmodule

/* rtl/core/stereo_soft_ring_modulator_top.sv */
// Top level of the stereo soft ring modulator: registers, queue, lanes, output.
//
//   channel  direction  handshake                payload
//   in       input      in_valid_i / in_stall_o  left_sample_i, right_sample_i
//   out      output     out_valid_o / out_stall_i left_out_o, right_out_o
//   cfg      input      cfg_we_i                 cfg_idx_i, cfg_data_i
//
// In the back end each stereo pair makes five passes through the shared sine
// multiplier, then runs the bit-serial square root, one root bit per cycle.
// Both channels run side by side.
// The front queues up to two pairs, so input is taken while the back end works.
// Reset clears phases and registers (wet level to full) and empties the queue.
// The output register holds a result under stall; a lane then waits in its done state.
module stereo_soft_ring_modulator_top #(
  parameter int unsigned SAMPLE_WIDTH = ssrm_pkg::SAMPLE_WIDTH_DEF,
  parameter int unsigned PHASE_WIDTH  = ssrm_pkg::PHASE_WIDTH_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [SAMPLE_WIDTH-1:0]  left_sample_i,
  input  logic [SAMPLE_WIDTH-1:0]  right_sample_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [SAMPLE_WIDTH-1:0]  left_out_o,
  output logic [SAMPLE_WIDTH-1:0]  right_out_o,
  input  logic                     cfg_we_i,
  input  logic [1:0]               cfg_idx_i,
  input  logic [31:0]              cfg_data_i
);

  localparam int unsigned SW    = SAMPLE_WIDTH;
  localparam int unsigned F     = SW - 1;
  localparam int unsigned MAG_W = SW + 1;
  localparam int unsigned ENT_W = 2 * SW + 64;

  logic [31:0]      left_step_q, right_step_q;
  logic [14:0]      soar_q;
  logic [16:0]      wet_q;
  logic [MAG_W-1:0] soar_s_q, soar_k_q;
  logic [16:0]      wet_eff_q, dry_q;
  logic [29:0]      soar_sq;
  logic [63:0]      soar_s_ext, soar_k_ext;

  logic             push, pop, full, empty;
  logic [ENT_W-1:0] push_data, head;

  ssrm_pkg::lane_status_t l_status, r_status;
  logic [SW-1:0]    l_result, r_result;
  logic             take;

  logic             out_valid_q;
  logic [SW-1:0]    left_out_q, right_out_q;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_step_q  <= '0;
      right_step_q <= '0;
      soar_q       <= '0;
      wet_q        <= ssrm_pkg::WET_FULL;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ssrm_pkg::CFG_LEFT_STEP:  left_step_q  <= cfg_data_i;
        ssrm_pkg::CFG_RIGHT_STEP: right_step_q <= cfg_data_i;
        ssrm_pkg::CFG_SOAR_LEVEL: soar_q       <= cfg_data_i[14:0];
        ssrm_pkg::CFG_WET_LEVEL:  wet_q        <= cfg_data_i[16:0];
        default: ;
      endcase
    end
  end

  // Threshold, knee and mix weights derived from the registers
  assign soar_sq    = 30'(soar_q) * 30'(soar_q);
  assign soar_s_ext = (64'(soar_q) << F) >> 16;
  assign soar_k_ext = (64'(soar_sq) << F) >> 32;

  always_ff @(posedge clk_i) begin
    soar_s_q  <= soar_s_ext[MAG_W-1:0];
    soar_k_q  <= soar_k_ext[MAG_W-1:0];
    wet_eff_q <= (wet_q > ssrm_pkg::WET_FULL) ? ssrm_pkg::WET_FULL : wet_q;
    dry_q     <= ssrm_pkg::WET_FULL -
                 ((wet_q > ssrm_pkg::WET_FULL) ? ssrm_pkg::WET_FULL : wet_q);
  end

  ssrm_front #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .PHASE_WIDTH  (PHASE_WIDTH)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .left_sample_i  (left_sample_i),
    .right_sample_i (right_sample_i),
    .left_step_i    (left_step_q),
    .right_step_i   (right_step_q),
    .full_i         (full),
    .push_o         (push),
    .data_o         (push_data)
  );

  ssrm_fifo #(
    .WIDTH (ENT_W),
    .DEPTH (ssrm_pkg::QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_data),
    .pop_i   (pop),
    .data_o  (head),
    .full_o  (full),
    .empty_o (empty)
  );

  // Both lanes start together and finish together
  assign pop  = !empty && l_status.idle && r_status.idle;
  assign take = l_status.done && r_status.done && (!out_valid_q || !out_stall_i);

  ssrm_lane #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_lane_left (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (pop),
    .sample_i (head[ENT_W-1 -: SW]),
    .phase_i  (head[63:32]),
    .soar_s_i (soar_s_q),
    .soar_k_i (soar_k_q),
    .wet_i    (wet_eff_q),
    .dry_i    (dry_q),
    .take_i   (take),
    .status_o (l_status),
    .result_o (l_result)
  );

  ssrm_lane #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_lane_right (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (pop),
    .sample_i (head[ENT_W-SW-1 -: SW]),
    .phase_i  (head[31:0]),
    .soar_s_i (soar_s_q),
    .soar_k_i (soar_k_q),
    .wet_i    (wet_eff_q),
    .dry_i    (dry_q),
    .take_i   (take),
    .status_o (r_status),
    .result_o (r_result)
  );

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (take) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      left_out_q  <= l_result;
      right_out_q <= r_result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign left_out_o  = left_out_q;
  assign right_out_o = right_out_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) l_status == r_status)
    else $error("lanes out of step");
  assert property (@(posedge clk_i) disable iff (!rst_ni) take |=> out_valid_q)
    else $error("result dropped at output register");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (out_valid_q && out_stall_i) |-> !take)
    else $error("stalled output overwritten");
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop |=> !l_status.idle)
    else $error("lane did not start on queue read");

endmodule

/* tb/tb.sv */
// Self-checking testbench of the stereo soft ring modulator.
`timescale 1ns / 1ps

module tb;

  localparam int unsigned SW = 24;
  localparam int unsigned FR = SW - 1;
  localparam int unsigned WATCHDOG = 20000;

  typedef struct packed {
    logic [SW-1:0] left;
    logic [SW-1:0] right;
  } pair_t;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          in_valid_i = 1'b0;
  logic          in_stall_o;
  logic [SW-1:0] left_sample_i = '0;
  logic [SW-1:0] right_sample_i = '0;
  logic          out_valid_o;
  logic          out_stall_i = 1'b0;
  logic [SW-1:0] left_out_o;
  logic [SW-1:0] right_out_o;
  logic          cfg_we_i = 1'b0;
  logic [1:0]    cfg_idx_i = ssrm_pkg::CFG_LEFT_STEP;
  logic [31:0]   cfg_data_i = '0;

  stereo_soft_ring_modulator_top u_dut (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Predictor state and registers
  logic [31:0] lphase, rphase, lstep, rstep;
  logic [14:0] soar;
  logic [16:0] wet;

  pair_t pending_q[$];
  pair_t modulated_q[$];
  int    errors = 0;
  int    accepted_in = 0;
  int    idle_cycles = 0;
  bit    calm = 1'b0;
  bit    in_fire = 1'b0;

  function automatic longint unsigned isqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else r >>= 1;
      b >>= 2;
    end
    return r;
  endfunction

  // Quarter-wave polynomial sine, magnitude at FR fraction bits
  function automatic longint unsigned sine_mag(logic [31:0] p, output bit neg);
    longint unsigned t, t2, s;
    t = p[29:0];
    if (p[30]) t = (64'd1 << 30) - t;
    t2 = (t * t) >> 30;
    s = ssrm_pkg::C7;
    s = ssrm_pkg::C5 - ((s * t2) >> 30);
    s = ssrm_pkg::C3 - ((s * t2) >> 30);
    s = ssrm_pkg::C1 - ((s * t2) >> 30);
    neg = p[31];
    return ((s * t) >> 30) >> (30 - FR);
  endfunction

  function automatic logic [SW-1:0] ring_mix(logic [SW-1:0] raw, logic [31:0] ph);
    longint x, md, mix, d;
    longint unsigned a, b, s, k, inner, outer, m, w;
    bit sneg;
    x = $signed(raw);
    b = sine_mag(ph, sneg);
    a = (x < 0) ? -x : x;
    s = (longint'(soar) << FR) >> 16;
    k = ((longint'(soar) * soar) << FR) >> 32;
    if (a < b + k) begin
      inner = b;
      outer = a + k;
    end else begin
      inner = a;
      outer = b + k;
    end
    m = isqrt(inner * outer);
    d = (m > s) ? longint'(m - s) : 0;
    md = 0;
    if (x != 0 && b != 0) md = ((x < 0) == sneg) ? d : -d;
    w = (wet > 17'd65536) ? 65536 : wet;
    mix = (longint'(w) * md + longint'(65536 - w) * x) >>> 16;
    if (mix > (longint'(1) << FR) - 1) mix = (longint'(1) << FR) - 1;
    if (mix < -(longint'(1) << FR)) mix = -(longint'(1) << FR);
    return mix[SW-1:0];
  endfunction

  // Driver: feeds queued pairs with random idle gaps, drives random output stalls
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || in_fire) begin
        if (pending_q.size() != 0 && (calm || $urandom_range(99) >= 38)) begin
          in_valid_i <= 1'b1;
          left_sample_i <= pending_q[0].left;
          right_sample_i <= pending_q[0].right;
          void'(pending_q.pop_front());
        end else in_valid_i <= 1'b0;
      end
      out_stall_i <= calm ? 1'b0 : ($urandom_range(99) < 38);
    end
  end

  // Monitor: predicts on input transactions, checks output transactions
  always @(posedge clk_i) begin
    pair_t exp_p;
    bit any;
    any = 1'b0;
    in_fire = rst_ni && in_valid_i && !in_stall_o;
    if (in_fire) begin
      any = 1'b1;
      accepted_in++;
      lphase = lphase + lstep;
      rphase = rphase + rstep;
      exp_p.left = ring_mix(left_sample_i, lphase);
      exp_p.right = ring_mix(right_sample_i, rphase);
      modulated_q.push_back(exp_p);
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      any = 1'b1;
      if (modulated_q.size() == 0) begin
        $error("output transaction with nothing expected");
        errors++;
      end else begin
        exp_p = modulated_q.pop_front();
        if (left_out_o !== exp_p.left) begin
          $error("left_out expected %h got %h", exp_p.left, left_out_o);
          errors++;
        end
        if (right_out_o !== exp_p.right) begin
          $error("right_out expected %h got %h", exp_p.right, right_out_o);
          errors++;
        end
      end
    end
    idle_cycles = any ? 0 : idle_cycles + 1;
  end

  // Watchdog
  always @(posedge clk_i) begin
    if (idle_cycles >= WATCHDOG) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      ssrm_pkg::CFG_LEFT_STEP:  lstep = val;
      ssrm_pkg::CFG_RIGHT_STEP: rstep = val;
      ssrm_pkg::CFG_SOAR_LEVEL: soar = val[14:0];
      ssrm_pkg::CFG_WET_LEVEL:  wet = val[16:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    int n;
    n = 0;
    while ((pending_q.size() != 0 || in_valid_i || modulated_q.size() != 0) && n < 200000) begin
      @(posedge clk_i);
      n++;
    end
    repeat (60) @(posedge clk_i);
  endtask

  function automatic logic [SW-1:0] rnd_sample();
    case ($urandom_range(5))
      0: return {1'b0, {(SW-1){1'b1}}};
      1: return {1'b1, {(SW-1){1'b0}}};
      2: return SW'($urandom_range(255));
      default: return SW'($urandom());
    endcase
  endfunction

  task automatic queue_pair(logic [SW-1:0] l, logic [SW-1:0] r);
    pair_t p;
    p.left = l;
    p.right = r;
    pending_q.push_back(p);
  endtask

  initial begin
    lphase = '0; rphase = '0; lstep = '0; rstep = '0;
    soar = '0; wet = ssrm_pkg::WET_FULL;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: zero step means zero sine, so output is zero at full wet
    queue_pair('0, '0);
    queue_pair({1'b0, {(SW-1){1'b1}}}, {1'b1, {(SW-1){1'b0}}});
    drain();
    // Quarter-turn left step hits every quadrant edge, right step is minus one LSB; max soar; full-scale left samples
    write_reg(ssrm_pkg::CFG_LEFT_STEP, 32'h4000_0000);
    write_reg(ssrm_pkg::CFG_RIGHT_STEP, 32'hFFFF_FFFF);
    write_reg(ssrm_pkg::CFG_SOAR_LEVEL, 32'd19661);
    for (int i = 0; i < 8; i++)
      queue_pair(i[0] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}},
                 i[1] ? 24'd0 : 24'hFFFFFF);
    drain();
    // Soar above range, wet above full, then dry-only mix
    write_reg(ssrm_pkg::CFG_SOAR_LEVEL, 32'h7FFF);
    write_reg(ssrm_pkg::CFG_WET_LEVEL, 32'h1FFFF);
    for (int i = 0; i < 5; i++) queue_pair(rnd_sample(), rnd_sample());
    drain();
    write_reg(ssrm_pkg::CFG_WET_LEVEL, 32'd0);
    for (int i = 0; i < 5; i++) queue_pair(rnd_sample(), rnd_sample());
    drain();

    // Random phases with changing settings
    for (int ph = 0; ph < 7; ph++) begin
      write_reg(ssrm_pkg::CFG_LEFT_STEP, $urandom());
      write_reg(ssrm_pkg::CFG_RIGHT_STEP, (ph == 3) ? 32'h8000_0000 : $urandom());
      write_reg(ssrm_pkg::CFG_SOAR_LEVEL, (ph == 1) ? 32'd0 : $urandom_range(19661));
      write_reg(ssrm_pkg::CFG_WET_LEVEL, (ph == 2) ? 32'd65536 : $urandom_range(65536));
      calm = (ph == 4);
      for (int i = 0; i < 100; i++) queue_pair(rnd_sample(), rnd_sample());
      drain();
    end
    calm = 1'b0;

    if (errors == 0 && modulated_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
